FILE: hw/rtl/kia_pkg.sv
`timescale 1ns / 1ps

package kia_pkg;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CsrAddrWidth-1:0] CSR_ADDR_WIFI_MODE        = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_ADDR_INITIAL_INTERVAL = 3'd4;

   localparam logic [15:0] CELL_MIN  = 16'd6000;
   localparam logic [15:0] CELL_MAX  = 16'd16800;
   localparam logic [15:0] WIFI_MIN  = 16'd9000;
   localparam logic [15:0] WIFI_MAX  = 16'd36000;
   localparam logic [17:0] STEP_BASE = 18'd1750;

   localparam logic [1:0] REGAIN_COUNT = 2'd3;

   localparam logic ACTION_RESTART   = 1'b0;
   localparam logic ACTION_HEARTBEAT = 1'b1;

   localparam logic [1:0] STAGE_CODE_GROWTH  = 2'd0;
   localparam logic [1:0] STAGE_CODE_BACKOFF = 2'd1;
   localparam logic [1:0] STAGE_CODE_STEADY  = 2'd2;

   typedef enum logic [2:0] {
      STAGE_GROWTH  = 3'b001,
      STAGE_BACKOFF = 3'b010,
      STAGE_STEADY  = 3'b100
   } stage_type;

   typedef struct packed {
      logic       action;
      logic       success;
      logic [6:0] jitter_draw;
   } req_type;

   typedef struct packed {
      logic [15:0] interval;
      logic [1:0]  stage;
   } rsp_type;

   typedef struct packed {
      logic        wifi_mode;
      logic [15:0] initial_interval;
   } cfg_type;

   typedef struct packed {
      stage_type   stage;
      logic [15:0] interval;
      logic [1:0]  success_count;
      logic        link_wifi;
   } state_type;

   function automatic logic [15:0] link_min(input logic wifi);
      return wifi ? WIFI_MIN : CELL_MIN;
   endfunction

   function automatic logic [15:0] link_max(input logic wifi);
      return wifi ? WIFI_MAX : CELL_MAX;
   endfunction

   function automatic logic [1:0] stage_code(input stage_type stage);
      logic [1:0] code;
      unique case (stage)
         STAGE_GROWTH:  code = STAGE_CODE_GROWTH;
         STAGE_BACKOFF: code = STAGE_CODE_BACKOFF;
         STAGE_STEADY:  code = STAGE_CODE_STEADY;
         default:       code = STAGE_CODE_GROWTH;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/keepalive_interval_adapter.sv
`timescale 1ns / 1ps

// Keep-alive interval adapter.
// Request channel (req_valid/req_ready/req_data) carries one transaction per
// event: a restart from the CSRs or a heartbeat result with a jitter draw.
// Response channel (rsp_valid/rsp_ready/rsp_data) returns exactly one
// transaction per request: the updated interval (tenths of a second) and
// the stage code (growth, backoff, steady).
// CSRs: wifi_mode at 0x0, initial_interval at 0x4, APB-style, pready tied
// high. Write them only while no transaction is in flight.
// Flow: a request is registered on acceptance and updated against the state
// when the response register is free or being read; that update also loads the
// response register and sets rsp_valid. Throughput: one transaction per
// cycle unless the response stalls; the single state update path (add,
// compare, 3/4 scale) sits between the request and response registers.
// Reset: state returns to growth, interval 6000, cellular limits; CSRs
// clear to zero; both channels empty.
// A stalled response holds the response register; one more request may
// still be taken into the request register, after which req_ready drops.

module keepalive_interval_adapter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  kia_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output kia_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kia_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [kia_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [kia_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import kia_pkg::*;

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   req_type   req_ff;
   logic      req_valid_ff;
   logic      req_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      advance;

   kia_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kia_update u_update (
      .item   (req_ff),
      .cfg    (cfg),
      .cur    (state_ff),
      .nxt    (state_in),
      .result (rsp_in)
   );

   assign advance      = req_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready    = ~req_valid_ff | advance;
   assign req_valid_in = (req_valid & req_ready) | (req_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.stage         <= STAGE_GROWTH;
         state_ff.interval      <= CELL_MIN;
         state_ff.success_count <= 2'd0;
         state_ff.link_wifi     <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_steady_at_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff.stage == STAGE_STEADY) |-> (state_ff.interval == link_max(state_ff.link_wifi)))
      else $error("steady stage without interval at link maximum");

   a_interval_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.interval <= link_max(state_ff.link_wifi))
      else $error("interval above link maximum");

   a_backoff_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.stage == STAGE_BACKOFF) |-> (state_ff.success_count != REGAIN_COUNT))
      else $error("backoff holds a full success count");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("update without response");

   a_stall_holds_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && !rsp_ready) |=> (req_valid_ff && $stable(req_ff)))
      else $error("pending request lost during response stall");

endmodule

FILE: hw/rtl/kia_csr.sv
`timescale 1ns / 1ps

module kia_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kia_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [kia_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [kia_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready,
   output kia_pkg::cfg_type                    cfg
);
   import kia_pkg::*;

   logic        wifi_mode_ff;
   logic        wifi_mode_in;
   logic [15:0] initial_interval_ff;
   logic [15:0] initial_interval_in;
   logic        write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      wifi_mode_in        = wifi_mode_ff;
      initial_interval_in = initial_interval_ff;
      if (write_en) begin
         case (csr_paddr)
            CSR_ADDR_WIFI_MODE:        wifi_mode_in        = csr_pwdata[0];
            CSR_ADDR_INITIAL_INTERVAL: initial_interval_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wifi_mode_ff        <= 1'b0;
         initial_interval_ff <= 16'd0;
      end else begin
         wifi_mode_ff        <= wifi_mode_in;
         initial_interval_ff <= initial_interval_in;
      end
   end

   always_comb begin
      case (csr_paddr)
         CSR_ADDR_WIFI_MODE: begin
            csr_prdata = {{(CsrDataWidth-1){1'b0}}, wifi_mode_ff};
         end
         CSR_ADDR_INITIAL_INTERVAL: begin
            csr_prdata = {{(CsrDataWidth-16){1'b0}}, initial_interval_ff};
         end
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.wifi_mode        = wifi_mode_ff;
   assign cfg.initial_interval = initial_interval_ff;

endmodule

FILE: hw/rtl/kia_update.sv
`timescale 1ns / 1ps

module kia_update (
   input  kia_pkg::req_type   item,
   input  kia_pkg::cfg_type   cfg,
   input  kia_pkg::state_type cur,
   output kia_pkg::state_type nxt,
   output kia_pkg::rsp_type   result
);
   import kia_pkg::*;

   logic [15:0] lo;
   logic [15:0] hi;
   logic [15:0] step_max;
   logic [17:0] step_sum;
   logic [17:0] scaled;
   logic [1:0]  count_inc;
   stage_type   mid_stage;

   assign lo        = link_min(cfg.wifi_mode);
   assign hi        = link_max(cfg.wifi_mode);
   assign step_max  = link_max(cur.link_wifi);
   assign step_sum  = {2'b00, cur.interval} + STEP_BASE + {11'd0, item.jitter_draw};
   // interval * 3 / 4, truncated
   assign scaled    = {1'b0, cur.interval, 1'b0} + {2'b00, cur.interval};
   assign count_inc = cur.success_count + 2'd1;

   always_comb begin
      nxt       = cur;
      mid_stage = cur.stage;
      if (item.action == ACTION_RESTART) begin
         nxt.link_wifi     = cfg.wifi_mode;
         nxt.stage         = STAGE_GROWTH;
         nxt.success_count = 2'd0;
         if (cfg.initial_interval >= lo && cfg.initial_interval <= hi) begin
            nxt.interval = cfg.initial_interval;
         end else begin
            nxt.interval = lo;
         end
      end else if (item.success) begin
         if (cur.stage == STAGE_BACKOFF) begin
            if (count_inc >= REGAIN_COUNT) begin
               mid_stage         = STAGE_GROWTH;
               nxt.success_count = 2'd0;
            end else begin
               nxt.success_count = count_inc;
            end
         end else if (cur.success_count < REGAIN_COUNT) begin
            nxt.success_count = count_inc;
         end
         nxt.stage = mid_stage;
         if (mid_stage == STAGE_GROWTH) begin
            if (step_sum >= {2'b00, step_max}) begin
               nxt.interval = step_max;
               nxt.stage    = STAGE_STEADY;
            end else begin
               nxt.interval = step_sum[15:0];
            end
         end
      end else begin
         nxt.success_count = 2'd0;
         if (cur.stage != STAGE_BACKOFF) begin
            nxt.stage    = STAGE_BACKOFF;
            nxt.interval = scaled[17:2];
         end
      end
   end

   assign result.interval = nxt.interval;
   assign result.stage    = stage_code(nxt.stage);

endmodule
